>>> design/ir_pulse_distance_decoder_unit_macros.svh
// assertion macros for the ir pulse-distance decoder
// used by the top level; expects clk and rst in scope
`ifndef IR_PULSE_DISTANCE_DECODER_UNIT_MACROS_SVH
`define IR_PULSE_DISTANCE_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define IRPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irpd assertion failed");

// next-cycle implication, checked outside reset
`define IRPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irpd assertion failed");

`endif

>>> design/irpd_pkg.sv
// shared types, constants and the command lookup for the ir decoder
// no dependencies
package irpd_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ZERO_MIN = 2'd0,
    REG_ZERO_MAX = 2'd1,
    REG_ONE_MIN  = 2'd2,
    REG_ONE_MAX  = 2'd3
  } cfg_reg_t;

  localparam int TICK_W = 24;

  // window reset values in clock ticks
  localparam logic [TICK_W-1:0] ZERO_MIN_RESET = 24'd20000;
  localparam logic [TICK_W-1:0] ZERO_MAX_RESET = 24'd68000;
  localparam logic [TICK_W-1:0] ONE_MIN_RESET  = 24'd72000;
  localparam logic [TICK_W-1:0] ONE_MAX_RESET  = 24'd120000;

  // command codes
  localparam logic [2:0] CMD_NONE        = 3'd0;
  localparam logic [2:0] CMD_FORWARD     = 3'd1;
  localparam logic [2:0] CMD_BACKWARD    = 3'd2;
  localparam logic [2:0] CMD_CLOCKWISE   = 3'd3;
  localparam logic [2:0] CMD_COUNTER_CW  = 3'd4;
  localparam logic [2:0] CMD_BALANCE_ON  = 3'd5;
  localparam logic [2:0] CMD_BALANCE_OFF = 3'd6;

  // received byte values for each command
  localparam logic [7:0] BYTE_FORWARD     = 8'd152;
  localparam logic [7:0] BYTE_BACKWARD    = 8'd204;
  localparam logic [7:0] BYTE_CLOCKWISE   = 8'd180;
  localparam logic [7:0] BYTE_COUNTER_CW  = 8'd120;
  localparam logic [7:0] BYTE_BALANCE_ON  = 8'd50;
  localparam logic [7:0] BYTE_BALANCE_OFF = 8'd70;

  typedef struct packed {
    logic [TICK_W-1:0] zero_min;
    logic [TICK_W-1:0] zero_max;
    logic [TICK_W-1:0] one_min;
    logic [TICK_W-1:0] one_max;
  } bit_windows_t;

  typedef struct packed {
    logic [31:0] frame_bits;
    logic [7:0]  data_byte;
    logic [2:0]  command;
    logic        balance_enabled;
    logic        bad_interval;
  } frame_result_t;

  // byte to command code
  function automatic logic [2:0] code_of_byte(input logic [7:0] b);
    logic [2:0] code;
    case (b)
      BYTE_FORWARD:     code = CMD_FORWARD;
      BYTE_BACKWARD:    code = CMD_BACKWARD;
      BYTE_CLOCKWISE:   code = CMD_CLOCKWISE;
      BYTE_COUNTER_CW:  code = CMD_COUNTER_CW;
      BYTE_BALANCE_ON:  code = CMD_BALANCE_ON;
      BYTE_BALANCE_OFF: code = CMD_BALANCE_OFF;
      default:          code = CMD_NONE;
    endcase
    return code;
  endfunction

endpackage

>>> design/irpd_bit_slicer.sv
// interval measurement and bit window classification
// depends on irpd_pkg
module irpd_bit_slicer (
  input  logic [31:0]           capture_time,
  input  logic [31:0]           last_capture,
  input  irpd_pkg::bit_windows_t windows,
  output logic                  bit_value,
  output logic                  bad
);
  import irpd_pkg::*;

  logic [31:0] delta;
  logic        in_zero;
  logic        in_one;

  // modulo 2^32 interval, so a timer wrap is harmless
  assign delta = capture_time - last_capture;

  // inclusive windows, zero window wins on overlap
  assign in_zero = (delta >= {8'd0, windows.zero_min}) && (delta <= {8'd0, windows.zero_max});
  assign in_one  = (delta >= {8'd0, windows.one_min}) && (delta <= {8'd0, windows.one_max});

  assign bit_value = !in_zero && in_one;
  assign bad       = !in_zero && !in_one;

endmodule

>>> design/irpd_frame_state.sv
// frame state: edge counter, bit shift register, error and balance flags
// depends on irpd_pkg and irpd_bit_slicer
module irpd_frame_state #(
  parameter int EDGES_PER_FRAME = 34
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [31:0]            capture_time,
  input  irpd_pkg::bit_windows_t windows,
  output logic                   emit,
  output irpd_pkg::frame_result_t result
);
  import irpd_pkg::*;

  localparam int CW = $clog2(EDGES_PER_FRAME);

  logic [CW-1:0] edge_count;
  logic [CW-1:0] edge_count_next;
  logic [31:0]   last_capture;
  logic [31:0]   bit_shift;
  logic [31:0]   bit_shift_next;
  logic          error_seen;
  logic          error_seen_next;
  logic          balance_on;
  logic          balance_on_next;
  logic          bit_value;
  logic          bad;
  logic          first_edge;
  logic          data_edge;
  logic [7:0]    data_byte;
  logic [2:0]    command;

  irpd_bit_slicer u_slicer (
    .capture_time (capture_time),
    .last_capture (last_capture),
    .windows      (windows),
    .bit_value    (bit_value),
    .bad          (bad)
  );

  // edge classification; the leader interval yields no bit
  assign first_edge = (edge_count == '0);
  assign data_edge  = (edge_count >= CW'(2));
  assign emit       = (edge_count == CW'(EDGES_PER_FRAME - 1));

  // next values for this edge
  always_comb begin
    if (first_edge) begin
      bit_shift_next  = '0;
      error_seen_next = 1'b0;
    end else if (data_edge) begin
      bit_shift_next  = {bit_shift[30:0], bit_value};
      error_seen_next = error_seen | bad;
    end else begin
      bit_shift_next  = bit_shift;
      error_seen_next = error_seen;
    end
    edge_count_next = emit ? '0 : edge_count + CW'(1);
  end

  // command decode and balance flag update on the last edge
  always_comb begin
    data_byte       = bit_shift_next[15:8];
    command         = code_of_byte(data_byte);
    balance_on_next = balance_on;
    if (emit && (command == CMD_BALANCE_ON)) begin
      balance_on_next = 1'b1;
    end else if (emit && (command == CMD_BALANCE_OFF)) begin
      balance_on_next = 1'b0;
    end
  end

  assign result.frame_bits      = bit_shift_next;
  assign result.data_byte       = data_byte;
  assign result.command         = command;
  assign result.balance_enabled = balance_on_next;
  assign result.bad_interval    = error_seen_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count   <= '0;
      last_capture <= '0;
      bit_shift    <= '0;
      error_seen   <= 1'b0;
      balance_on   <= 1'b1;
    end else if (step) begin
      edge_count   <= edge_count_next;
      last_capture <= capture_time;
      bit_shift    <= bit_shift_next;
      error_seen   <= error_seen_next;
      balance_on   <= balance_on_next;
    end
  end

endmodule

>>> design/ir_pulse_distance_decoder_unit.sv
// top level of the ir pulse-distance frame decoder
// depends on irpd_pkg, irpd_frame_state and ir_pulse_distance_decoder_unit_macros.svh
//
// Takes one falling-edge timestamp per request and gives one result request
// per frame of EDGES_PER_FRAME edges: 32 decoded bits, the data byte, a command
// code, the balance flag and an error flag. The leader interval is skipped; each
// later interval is sorted into a bit by the zero and one tick windows (inclusive,
// zero window first), an interval in neither gives a zero bit and sets the error
// flag. One edge is accepted every cycle while input ready is high: it is held in
// an input register, decoded by the interval subtract, window compares and shift,
// and a frame result is loaded into the output register. Input ready drops only
// while the output register holds an untaken result and the held edge ends a
// frame. The windows may be rewritten only while no edge is in flight.
`include "ir_pulse_distance_decoder_unit_macros.svh"

module ir_pulse_distance_decoder_unit #(
  parameter int EDGES_PER_FRAME = 34
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] capture_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] frame_bits,
  output logic [7:0]  data_byte,
  output logic [2:0]  command,
  output logic        balance_enabled,
  output logic        bad_interval
);
  import irpd_pkg::*;

  bit_windows_t  windows;
  logic          s1_valid;
  logic [31:0]   s1_capture;
  logic          s1_emits;
  logic          s1_advance;
  frame_result_t s1_result;
  frame_result_t out_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      windows.zero_min <= ZERO_MIN_RESET;
      windows.zero_max <= ZERO_MAX_RESET;
      windows.one_min  <= ONE_MIN_RESET;
      windows.one_max  <= ONE_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_MIN: windows.zero_min <= cfg_data;
        REG_ZERO_MAX: windows.zero_max <= cfg_data;
        REG_ONE_MIN:  windows.one_min  <= cfg_data;
        REG_ONE_MAX:  windows.one_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // held edge moves on unless it ends a frame and the output is still full
  assign s1_advance = s1_valid && (!s1_emits || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_capture <= capture_time;
    end
  end

  irpd_frame_state #(
    .EDGES_PER_FRAME (EDGES_PER_FRAME)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_advance),
    .capture_time (s1_capture),
    .windows      (windows),
    .emit         (s1_emits),
    .result       (s1_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_emits) begin
      out_result <= s1_result;
    end
  end

  assign frame_bits      = out_result.frame_bits;
  assign data_byte       = out_result.data_byte;
  assign command         = out_result.command;
  assign balance_enabled = out_result.balance_enabled;
  assign bad_interval    = out_result.bad_interval;

  // checks
  `IRPD_ASSERT_NEXT(a_frame_end_loads_output, s1_advance && s1_emits, out_valid)
  `IRPD_ASSERT_NEXT(a_held_edge_kept, s1_valid && !s1_advance, s1_valid)
  `IRPD_ASSERT_NOW(a_balance_on_cmd, out_valid && (command == CMD_BALANCE_ON), balance_enabled)
  `IRPD_ASSERT_NOW(a_balance_off_cmd, out_valid && (command == CMD_BALANCE_OFF), !balance_enabled)

endmodule

>>> dv/tb_ir_pulse_distance_decoder_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the ir pulse-distance frame decoder
// depends on irpd_pkg and ir_pulse_distance_decoder_unit; frames are predicted in a class

module tb_ir_pulse_distance_decoder_unit;
  import irpd_pkg::*;

  localparam int FRAME_EDGES      = 34;
  localparam int SETTLE_CYCLES    = 8;
  localparam int STALL_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int FRAMES_PER_PHASE = 4;
  localparam int NUM_PHASES       = 6;

  // decoder model plus the queue of frames still owed by the block
  class ir_frame_tracker;
    bit_windows_t  windows;
    int unsigned   edge_count;
    logic [31:0]   last_capture;
    logic [31:0]   bit_shift;
    logic          error_seen;
    logic          balance_on;
    frame_result_t expected_frames[$];
    int            mismatches;

    function new();
      windows      = '{ZERO_MIN_RESET, ZERO_MAX_RESET, ONE_MIN_RESET, ONE_MAX_RESET};
      edge_count   = 0;
      last_capture = '0;
      bit_shift    = '0;
      error_seen   = 1'b0;
      balance_on   = 1'b1;
      mismatches   = 0;
    endfunction

    function void set_window(cfg_reg_t idx, logic [23:0] value);
      case (idx)
        REG_ZERO_MIN: windows.zero_min = value;
        REG_ZERO_MAX: windows.zero_max = value;
        REG_ONE_MIN:  windows.one_min  = value;
        REG_ONE_MAX:  windows.one_max  = value;
        default: ;
      endcase
    endfunction

    // one accepted edge: decode the interval, close the frame on its last edge
    function void note_edge(logic [31:0] stamp);
      logic [31:0]   gap;
      logic          decoded;
      frame_result_t fr;
      if (edge_count == 0) begin
        bit_shift  = '0;
        error_seen = 1'b0;
      end else if (edge_count >= 2) begin
        gap = stamp - last_capture;
        // zero window has priority when the windows overlap
        if (gap >= {8'd0, windows.zero_min} && gap <= {8'd0, windows.zero_max}) begin
          decoded = 1'b0;
        end else if (gap >= {8'd0, windows.one_min} && gap <= {8'd0, windows.one_max}) begin
          decoded = 1'b1;
        end else begin
          decoded    = 1'b0;
          error_seen = 1'b1;
        end
        bit_shift = {bit_shift[30:0], decoded};
      end
      last_capture = stamp;
      edge_count++;
      if (edge_count == FRAME_EDGES) begin
        edge_count   = 0;
        fr.frame_bits = bit_shift;
        fr.data_byte  = bit_shift[15:8];
        case (fr.data_byte)
          BYTE_FORWARD:     fr.command = CMD_FORWARD;
          BYTE_BACKWARD:    fr.command = CMD_BACKWARD;
          BYTE_CLOCKWISE:   fr.command = CMD_CLOCKWISE;
          BYTE_COUNTER_CW:  fr.command = CMD_COUNTER_CW;
          BYTE_BALANCE_ON:  fr.command = CMD_BALANCE_ON;
          BYTE_BALANCE_OFF: fr.command = CMD_BALANCE_OFF;
          default:          fr.command = CMD_NONE;
        endcase
        if (fr.command == CMD_BALANCE_ON) balance_on = 1'b1;
        else if (fr.command == CMD_BALANCE_OFF) balance_on = 1'b0;
        fr.balance_enabled = balance_on;
        fr.bad_interval    = error_seen;
        expected_frames.push_back(fr);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        $display("%0t: frame result with none expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_frames.pop_front();
      compare_field("frame_bits", want.frame_bits, got.frame_bits);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("command", want.command, got.command);
      compare_field("balance_enabled", want.balance_enabled, got.balance_enabled);
      compare_field("bad_interval", want.bad_interval, got.bad_interval);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  cfg_reg_t    cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] capture_time;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] frame_bits;
  logic [7:0]  data_byte;
  logic [2:0]  command;
  logic        balance_enabled;
  logic        bad_interval;

  int              send_idle_pct;
  int              recv_idle_pct;
  bit              stall_request;
  ir_frame_tracker tracker;

  ir_pulse_distance_decoder_unit #(
    .EDGES_PER_FRAME(FRAME_EDGES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .capture_time(capture_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_bits(frame_bits),
    .data_byte(data_byte),
    .command(command),
    .balance_enabled(balance_enabled),
    .bad_interval(bad_interval)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random back-pressure, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // check results first, then log the accepted edge
  always @(posedge clk) begin : monitor
    frame_result_t seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen = '{frame_bits, data_byte, command, balance_enabled, bad_interval};
        tracker.check_frame(seen);
      end
      if (in_valid && in_ready) tracker.note_edge(capture_time);
    end
  end

  // watchdog on cycles with no request moving
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // interval that lands in the wanted window, often right on a bound
  function automatic logic [31:0] pick_gap(logic want_one);
    logic [23:0] lo;
    logic [23:0] hi;
    int unsigned roll;
    lo   = want_one ? tracker.windows.one_min : tracker.windows.zero_min;
    hi   = want_one ? tracker.windows.one_max : tracker.windows.zero_max;
    roll = $urandom_range(9, 0);
    if (lo > hi) return $urandom_range(200000, 0);
    if (roll == 0) return {8'd0, lo};
    if (roll == 1) return {8'd0, hi};
    return $urandom_range(hi, lo);
  endfunction

  // interval meant to miss both windows
  function automatic logic [31:0] stray_gap();
    case ($urandom_range(3, 0))
      0:       return $urandom;
      1:       return {8'd0, tracker.windows.one_max} + 32'd1 + $urandom_range(500, 0);
      2:       return {8'd0, tracker.windows.zero_max} + 32'd1;
      default: return {8'd0, tracker.windows.zero_min} - 32'd1;
    endcase
  endfunction

  // mostly command bytes, sometimes anything
  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(9, 0))
      0:       return BYTE_FORWARD;
      1:       return BYTE_BACKWARD;
      2:       return BYTE_CLOCKWISE;
      3:       return BYTE_COUNTER_CW;
      4:       return BYTE_BALANCE_ON;
      5:       return BYTE_BALANCE_OFF;
      default: return $urandom_range(255, 0);
    endcase
  endfunction

  // one edge request; called and returns at a falling edge
  task automatic send_edge(logic [31:0] stamp);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    capture_time <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // full frame of edges; skip_edge drops one edge to break the framing
  task automatic send_frame(logic [7:0] data, int bad_pct, int skip_edge);
    logic [31:0] word;
    logic [31:0] stamp;
    word  = {16'($urandom), data, 8'($urandom)};
    stamp = $urandom;
    for (int e = 0; e < FRAME_EDGES; e++) begin
      if (e == 1) stamp += $urandom_range(400000, 1000);
      else if (e >= 2) begin
        if ($urandom_range(99, 0) < bad_pct) stamp += stray_gap();
        else stamp += pick_gap(word[FRAME_EDGES - 1 - e]);
      end
      if (e != skip_edge) send_edge(stamp);
    end
  endtask

  // let in-flight edges and owed frames drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.expected_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    tracker.set_window(idx, value);
    @(negedge clk);
  endtask

  task automatic set_windows(logic [23:0] zmin, logic [23:0] zmax,
                             logic [23:0] omin, logic [23:0] omax);
    write_reg(REG_ZERO_MIN, zmin);
    write_reg(REG_ZERO_MAX, zmax);
    write_reg(REG_ONE_MIN, omin);
    write_reg(REG_ONE_MAX, omax);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    logic [31:0] gaps[32];
    logic [31:0] word;
    logic [31:0] stamp;
    tracker       = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_ZERO_MIN;
    cfg_data      = '0;
    in_valid      = 1'b0;
    capture_time  = '0;
    send_idle_pct = 11;
    recv_idle_pct = 69;
    stall_request = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frame at reset windows: bounds, just-outside values, zero and
    // all-ones intervals, timer wrap right after the leader, balance-off byte
    word = {16'hA5C3, BYTE_BALANCE_OFF, 8'h3C};
    gaps[0] = {8'd0, ZERO_MIN_RESET};
    gaps[1] = {8'd0, ZERO_MAX_RESET};
    gaps[2] = {8'd0, ONE_MIN_RESET};
    gaps[3] = {8'd0, ONE_MAX_RESET};
    gaps[4] = {8'd0, ZERO_MIN_RESET} - 32'd1;
    gaps[5] = {8'd0, ZERO_MAX_RESET} + 32'd1;
    gaps[6] = {8'd0, ONE_MIN_RESET} - 32'd1;
    gaps[7] = {8'd0, ONE_MAX_RESET} + 32'd1;
    gaps[8] = 32'd0;
    gaps[9] = 32'hFFFF_FFFF;
    for (int i = 10; i < 32; i++) gaps[i] = pick_gap(word[31 - i]);
    stamp = 32'd0;
    send_edge(stamp);
    stamp = 32'hFFFF_FFFF;
    send_edge(stamp);
    for (int i = 0; i < 32; i++) begin
      stamp += gaps[i];
      send_edge(stamp);
    end

    // random phases, each with its own windows, and an idle mix per pair of phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 69;
      end else if (p < 4) begin
        send_idle_pct = 69;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: set_windows(24'd1000, 24'd90000, 24'd50000, 24'd150000);     // overlapping
        1: set_windows(24'd0, 24'd0, 24'd1, 24'hFF_FFFF);
        2: set_windows(24'h80_0000, 24'hFF_FFFF, 24'd0, 24'h7F_FFFF);
        3: set_windows(24'hFF_FFFF, 24'd0, 24'd100, 24'd5000);         // empty zero window
        4: set_windows(ZERO_MIN_RESET, ZERO_MAX_RESET, ONE_MIN_RESET, ONE_MAX_RESET);
        default: set_windows(24'd20000, 24'd20000, 24'd20001, 24'd20001);
      endcase
      // long result hold-off so the block fills and stalls its input
      if (p == 4) stall_request = 1'b1;
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        if ($urandom_range(9, 0) == 0) send_edge($urandom);
        send_frame(pick_data_byte(),
                   ($urandom_range(4, 0) == 0) ? 8 : 0,
                   ($urandom_range(9, 0) == 0) ? int'($urandom_range(33, 1)) : -1);
      end
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.expected_frames.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
